/* sv/ibd_pkg.sv */
// ----------------------------------------------------------------------------
// ibd_pkg
// Shared types and constants for the integrating button debouncer.
// ----------------------------------------------------------------------------
package ibd_pkg;

   typedef enum logic [1:0] {
      EV_NONE     = 2'd0,
      EV_PRESSED  = 2'd1,
      EV_RELEASED = 2'd2,
      EV_HELD     = 2'd3
   } event_type;

   typedef enum logic {
      CSR_CONFIDENCE_MAX     = 1'b0,
      CSR_LONG_PRESS_SAMPLES = 1'b1
   } csr_index_type;

   localparam int unsigned CONF_W = 8;
   localparam int unsigned LONG_W = 16;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [CONF_W-1:0] CONFIDENCE_MAX_RESET     = 8'd10;
   localparam logic [LONG_W-1:0] LONG_PRESS_SAMPLES_RESET = 16'd500;

   typedef struct packed {
      logic [CONF_W-1:0] confidence_max;
      logic [LONG_W-1:0] long_press_samples;
   } cfg_type;

   typedef struct packed {
      event_type event_code;
      logic      is_pressed;
      logic      level_changed;
   } result_type;

endpackage

/* sv/ibd_core.sv */
// ----------------------------------------------------------------------------
// ibd_core
// Debounce state (confidence, level, hold counter) and its one-tick update.
// ----------------------------------------------------------------------------
module ibd_core #(
   parameter int unsigned HOLD_COUNT_WIDTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic                pin_level,
   input  ibd_pkg::cfg_type    cfg,
   output ibd_pkg::result_type result
);

   localparam int unsigned CMP_W =
      (HOLD_COUNT_WIDTH > ibd_pkg::LONG_W) ? HOLD_COUNT_WIDTH : ibd_pkg::LONG_W;

   logic [ibd_pkg::CONF_W-1:0]   confidence_ff, confidence_in;
   logic                         level_ff, level_in;
   logic [HOLD_COUNT_WIDTH-1:0]  hold_ff, hold_in;
   logic                         done_ff, done_in;
   logic                         press, release_now, held;
   ibd_pkg::event_type           ev;

   always_comb begin
      // saturating confidence integrator
      if (pin_level) begin
         if (confidence_ff >= cfg.confidence_max) begin
            confidence_in = cfg.confidence_max;
         end else begin
            confidence_in = confidence_ff + 1'b1;
         end
      end else if (confidence_ff != '0) begin
         confidence_in = confidence_ff - 1'b1;
      end else begin
         confidence_in = confidence_ff;
      end

      press       = (confidence_in == '0) && level_ff;
      release_now = !press && (confidence_in == cfg.confidence_max) && !level_ff;

      priority if (press) begin
         level_in = 1'b0;
      end else if (release_now) begin
         level_in = 1'b1;
      end else begin
         level_in = level_ff;
      end

      // hold counter restarts on a press and saturates at all ones
      if (press) begin
         hold_in = '0;
      end else if (!level_in && (hold_ff != '1)) begin
         hold_in = hold_ff + 1'b1;
      end else begin
         hold_in = hold_ff;
      end

      held = !level_in && !(done_ff && !press) &&
             (CMP_W'(hold_in) > CMP_W'(cfg.long_press_samples));
      done_in = held ? 1'b1 : (press ? 1'b0 : done_ff);

      priority if (held) begin
         ev = ibd_pkg::EV_HELD;
      end else if (press) begin
         ev = ibd_pkg::EV_PRESSED;
      end else if (release_now) begin
         ev = ibd_pkg::EV_RELEASED;
      end else begin
         ev = ibd_pkg::EV_NONE;
      end

      result.event_code    = ev;
      result.is_pressed    = !level_in;
      result.level_changed = (ev != ibd_pkg::EV_NONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         confidence_ff <= ibd_pkg::CONFIDENCE_MAX_RESET;
         level_ff      <= 1'b1;
         hold_ff       <= '0;
         done_ff       <= 1'b0;
      end else if (step) begin
         confidence_ff <= confidence_in;
         level_ff      <= level_in;
         hold_ff       <= hold_in;
         done_ff       <= done_in;
      end
   end

endmodule

/* sv/integrating_button_debouncer_unit.sv */
// ----------------------------------------------------------------------------
// integrating_button_debouncer_unit
// Integrating button debouncer with press, release and long-hold events.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one raw pin sample per request (1 released, 0 pressed);
//   rsp_* returns one result per request: event code, debounced pressed
//   level and a changed flag.
//   csr_* writes confidence_max (index 0) and long_press_samples (index 1);
//   write only while no request is in flight.
// Pipeline: a request is registered in the input register on acceptance
//   and its result is then registered in the output register.
// Throughput: one request per cycle while the output is not stalled; the
//   counter update between the registers is each sample's single pass.
// Reset: synchronous; the button is taken as stably released, confidence at
//   10, long press after 500 samples, both registers empty.
// Stall: when rsp_tready is low the result holds in the output register and
//   one more request may wait in the input register; req_tready then drops.
// ----------------------------------------------------------------------------
module integrating_button_debouncer_unit #(
   parameter int unsigned HOLD_COUNT_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] pin_level, [7:1] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [1:0] event_code, [2] is_pressed,
                                    // [3] level_changed, [7:4] zero
   input  logic        csr_we,
   input  logic [0:0]  csr_addr,
   input  logic [ibd_pkg::CSR_DATA_W-1:0] csr_wdata
);

   ibd_pkg::cfg_type    cfg_ff;
   logic                in_valid_ff;
   logic                pin_ff;
   logic                out_valid_ff;
   ibd_pkg::result_type out_ff;
   ibd_pkg::result_type result;
   logic                out_load;
   logic                step;

   assign out_load   = !out_valid_ff || rsp_tready;
   assign step       = in_valid_ff && out_load;
   assign req_tready = !in_valid_ff || out_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.confidence_max     <= ibd_pkg::CONFIDENCE_MAX_RESET;
         cfg_ff.long_press_samples <= ibd_pkg::LONG_PRESS_SAMPLES_RESET;
      end else if (csr_we) begin
         unique case (ibd_pkg::csr_index_type'(csr_addr))
            ibd_pkg::CSR_CONFIDENCE_MAX: begin
               cfg_ff.confidence_max <= csr_wdata[ibd_pkg::CONF_W-1:0];
            end
            ibd_pkg::CSR_LONG_PRESS_SAMPLES: begin
               cfg_ff.long_press_samples <= csr_wdata[ibd_pkg::LONG_W-1:0];
            end
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         pin_ff <= req_tdata[0];
      end
   end

   ibd_core #(
      .HOLD_COUNT_WIDTH(HOLD_COUNT_WIDTH)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .pin_level(pin_ff),
      .cfg      (cfg_ff),
      .result   (result)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, out_ff.level_changed, out_ff.is_pressed,
                        out_ff.event_code};

endmodule

/* sv/ibd_checker.sv */
// ----------------------------------------------------------------------------
// ibd_checker
// Port-level checks for the debouncer, bound to the top level.
// ----------------------------------------------------------------------------
module ibd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   // changed flag follows the event code
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[3] == (rsp_tdata[1:0] != ibd_pkg::EV_NONE)))
      else $error("level_changed disagrees with event_code");

   // a press or a long hold leaves the button pressed
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[1:0] == ibd_pkg::EV_PRESSED ||
                      rsp_tdata[1:0] == ibd_pkg::EV_HELD))
      |-> rsp_tdata[2])
      else $error("press or hold event without pressed level");

   // a release leaves the button released
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1:0] == ibd_pkg::EV_RELEASED) |-> !rsp_tdata[2])
      else $error("release event with pressed level");

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

endmodule

bind integrating_button_debouncer_unit ibd_checker u_ibd_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);

/* tb/debounce_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// debounce_checker
// Watches the sample and result channels of the button debouncer, keeps its
// own confidence and hold counters, and compares every result field by field
// with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module debounce_checker #(
   parameter int unsigned HOLD_W = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,   // [0] pin_level, [7:1] zero
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,   // [1:0] event_code, [2] is_pressed,
                                   // [3] level_changed, [7:4] zero
   input  logic       csr_we,
   input  logic [0:0] csr_addr,
   input  logic [ibd_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int         mismatches,
   output int         outstanding,
   output int         samples,
   output int         presses,
   output int         releases,
   output int         holds
);
   import ibd_pkg::*;

   logic [CONF_W-1:0] ceiling;
   logic [LONG_W-1:0] hold_limit;
   logic [CONF_W-1:0] confidence_q;
   logic              released_q;
   logic [HOLD_W-1:0] hold_ticks;
   logic              held_fired;

   result_type expected_events[$];

   function automatic result_type debounce_sample(input logic pin);
      result_type outcome;
      event_type  ev;
      logic       just_pressed;
      ev = EV_NONE;
      just_pressed = 1'b0;
      if (pin) begin
         // a lowered ceiling pulls confidence straight down to it
         if (confidence_q >= ceiling) confidence_q = ceiling;
         else confidence_q = confidence_q + 1'b1;
      end else if (confidence_q != '0) begin
         confidence_q = confidence_q - 1'b1;
      end
      if (confidence_q == '0 && released_q) begin
         released_q = 1'b0;
         hold_ticks = '0;
         held_fired = 1'b0;
         just_pressed = 1'b1;
         ev = EV_PRESSED;
      end else if (confidence_q == ceiling && !released_q) begin
         released_q = 1'b1;
         ev = EV_RELEASED;
      end
      if (!released_q && !just_pressed && hold_ticks != '1) hold_ticks = hold_ticks + 1'b1;
      if (!released_q && !held_fired && hold_ticks > hold_limit) begin
         ev = EV_HELD;
         held_fired = 1'b1;
      end
      outcome.event_code = ev;
      outcome.is_pressed = !released_q;
      outcome.level_changed = (ev != EV_NONE);
      return outcome;
   endfunction

   always @(posedge clock) begin : monitor
      result_type want;
      if (reset) begin
         ceiling = CONFIDENCE_MAX_RESET;
         hold_limit = LONG_PRESS_SAMPLES_RESET;
         confidence_q = CONFIDENCE_MAX_RESET;
         released_q = 1'b1;
         hold_ticks = '0;
         held_fired = 1'b0;
         expected_events.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_events.size() == 0) begin
               $error("result with no request outstanding: tdata %02h", rsp_tdata);
               mismatches++;
            end else begin
               want = expected_events.pop_front();
               if (rsp_tdata[1:0] !== want.event_code) begin
                  $error("event_code: expected %0d, got %0d", want.event_code, rsp_tdata[1:0]);
                  mismatches++;
               end
               if (rsp_tdata[2] !== want.is_pressed) begin
                  $error("is_pressed: expected %0d, got %0d", want.is_pressed, rsp_tdata[2]);
                  mismatches++;
               end
               if (rsp_tdata[3] !== want.level_changed) begin
                  $error("level_changed: expected %0d, got %0d",
                         want.level_changed, rsp_tdata[3]);
                  mismatches++;
               end
               if (rsp_tdata[7:4] !== 4'd0) begin
                  $error("padding: expected 0, got %0h", rsp_tdata[7:4]);
                  mismatches++;
               end
               case (want.event_code)
                  EV_PRESSED:  presses++;
                  EV_RELEASED: releases++;
                  EV_HELD:     holds++;
                  default: ;
               endcase
            end
         end
         if (req_tvalid && req_tready) begin
            expected_events.push_back(debounce_sample(req_tdata[0]));
            samples++;
         end
         if (csr_we) begin
            case (csr_addr)
               CSR_CONFIDENCE_MAX:     ceiling = csr_wdata[CONF_W-1:0];
               CSR_LONG_PRESS_SAMPLES: hold_limit = csr_wdata[LONG_W-1:0];
               default: ;
            endcase
         end
      end
      outstanding <= expected_events.size();
   end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the integrating button debouncer: directed bounce, press,
// release and long-hold sequences at the threshold extremes, a hold limit
// lowered under a running count, then random bouncy press sequences under
// several threshold settings with random idling on both channels.
// ----------------------------------------------------------------------------
module tb;
   import ibd_pkg::*;

   localparam int unsigned STALL_LIMIT   = 1000;
   localparam int unsigned PHASE_SAMPLES = 20;
   localparam int unsigned RANDOM_PHASES = 6;
   localparam int unsigned LONG_STALL    = 48;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = 8'd0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [0:0]            csr_addr = CSR_CONFIDENCE_MAX;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   bit idle_on = 1'b1;
   bit stall_request = 1'b0;
   bit stall_launched = 1'b0;

   int mismatches, outstanding, samples, presses, releases, holds;
   int phase_count;
   int settings_used;
   int quiet_cycles;
   logic [CONF_W-1:0] cur_ceiling = CONFIDENCE_MAX_RESET;
   logic [LONG_W-1:0] cur_hold_limit = LONG_PRESS_SAMPLES_RESET;

   always #4 clock = ~clock;

   integrating_button_debouncer_unit #(
      .HOLD_COUNT_WIDTH(16)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata)
   );

   debounce_checker #(
      .HOLD_W(16)
   ) watch (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata),
      .mismatches(mismatches),
      .outstanding(outstanding),
      .samples(samples),
      .presses(presses),
      .releases(releases),
      .holds(holds)
   );

   // result side: short random back-pressure, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (stall_request) begin
            stall_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_STALL) @(posedge clock);
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_sample(input logic pin);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         req_tdata <= 8'($urandom_range(0, 1));
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'd0, pin};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      phase_count++;
   endtask

   task automatic send_run(input logic level, input int len, input int flip_odds);
      logic pin;
      for (int k = 0; k < len; k++) begin
         pin = level;
         // contact bounce flips a sample now and then
         if (flip_odds > 0 && $urandom_range(0, flip_odds - 1) == 0) pin = ~level;
         send_sample(pin);
      end
   endtask

   task automatic settle;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic load_thresholds(input logic [CONF_W-1:0] ceiling,
                                  input logic [LONG_W-1:0] limit);
      csr_we <= 1'b1;
      csr_addr <= CSR_CONFIDENCE_MAX;
      csr_wdata <= CSR_DATA_W'(ceiling);
      @(posedge clock);
      csr_addr <= CSR_LONG_PRESS_SAMPLES;
      csr_wdata <= limit;
      @(posedge clock);
      csr_we <= 1'b0;
      cur_ceiling = ceiling;
      cur_hold_limit = limit;
      settings_used++;
   endtask

   initial begin : stimulus
      logic [10:0] quick_sequence;
      int          zeros_len;
      int          hold_span;
      int          choice;
      quick_sequence = 11'b000_1011_0000;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset thresholds: saturated high, then a single bounce
      send_run(1'b1, 2, 0);
      send_sample(1'b0);
      send_sample(1'b1);
      settle;

      // tightest thresholds: press, held, release and rapid toggling
      load_thresholds(8'd1, 16'd1);
      for (int k = 0; k < 11; k++) send_sample(quick_sequence[k]);
      settle;

      // widest hold limit: a long press never fires
      idle_on = 1'b0;
      load_thresholds(8'd1, 16'hFFFF);
      send_run(1'b0, 20, 0);
      settle;
      // limit dropped below the running count: no second hold fires, as this press already held
      load_thresholds(8'd1, 16'd5);
      send_run(1'b0, 2, 0);
      send_run(1'b1, 2, 0);
      settle;
      idle_on = 1'b1;

      // widest ceiling, then a lowered ceiling with confidence above it
      load_thresholds(8'hFF, 16'd3);
      send_run(1'b0, 300, 0);
      send_run(1'b1, 260, 0);
      settle;
      load_thresholds(8'd4, 16'd3);
      send_sample(1'b0);
      send_sample(1'b1);
      send_run(1'b0, 8, 0);
      send_run(1'b1, 6, 0);
      settle;

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0:       load_thresholds(8'd1, 16'd1);
            3:       load_thresholds(8'($urandom_range(1, 40)), 16'($urandom_range(1, 65535)));
            default: load_thresholds(8'($urandom_range(2, 12)), 16'($urandom_range(1, 40)));
         endcase
         if (phase == RANDOM_PHASES - 1) idle_on = 1'b0;
         phase_count = 0;
         while (phase_count < PHASE_SAMPLES) begin
            // long hold-off on the result side while samples keep coming
            if (phase == 2 && !stall_launched) begin
               stall_request = 1'b1;
               stall_launched = 1'b1;
            end
            choice = $urandom_range(0, 9);
            if (choice == 0) begin
               send_run(1'($urandom_range(0, 1)), $urandom_range(1, 12), 2);
            end else begin
               hold_span = (cur_hold_limit > 60) ? 60 : int'(cur_hold_limit);
               zeros_len = $urandom_range(1, int'(cur_ceiling) + hold_span + 6);
               send_run(1'b0, zeros_len, (choice < 6) ? 0 : 8);
               send_run(1'b1, $urandom_range(1, int'(cur_ceiling) + 6), (choice < 6) ? 0 : 8);
            end
         end
         settle;
      end

      $display("%0d samples checked under %0d threshold settings", samples, settings_used);
      $display("events seen: %0d presses, %0d releases, %0d long holds",
               presses, releases, holds);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
